// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL of the oscillator ring.
// Needs a clk_i clock and an active-low rst_ni reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising clock edge out of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/cors_pkg.sv =====
// Shared types, codes, constants and the saturation helper for the oscillator ring.
// No dependencies.
`default_nettype none

package cors_pkg;

  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QTwo = 32'sh0002_0000;

  // quotient bits produced by the serial divider
  localparam int unsigned DivSteps = 32;

  localparam logic signed [31:0] ThetaRst    = 32'sd32768;
  localparam logic signed [31:0] CouplingRst = 32'sd49152;
  localparam logic signed [31:0] CurrentRst  = 32'sd13107;
  localparam logic signed [31:0] AlphaRst    = 32'sd393216;
  localparam logic signed [31:0] EpsilonRst  = 32'sd1311;
  localparam logic signed [31:0] InvBetaRst  = 32'sd655360;
  localparam logic [30:0]        TimeStepRst = 31'd655;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeStep = 2'd1,
    ModeRead = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CfgTheta    = 3'd0,
    CfgCoupling = 3'd1,
    CfgCurrent  = 3'd2,
    CfgAlpha    = 3'd3,
    CfgEpsilon  = 3'd4,
    CfgInvBeta  = 3'd5,
    CfgTimeStep = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/cors_mul.sv =====
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Uses nothing from the package.
`default_nettype none

module cors_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== design/cors_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tanh table build.
// Depends on cors_pkg (div_status_t, DivSteps).
`default_nettype none

module cors_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          num_i,
  input  logic [31:0]          den_i,
  output logic [31:0]          quot_o,
  output cors_pkg::div_status_t status_o
);
  import cors_pkg::*;

  logic [31:0] rem_q, num_q, den_q, quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial, diff;
  logic        ge;

  // numerator high word must already be below the divisor
  assign trial = {rem_q, num_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[63:32];
      num_q <= num_i[31:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      num_q <= {num_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign quot_o   = quo_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== design/cors_store.sv =====
// Neuron x and y memories: one write port, x read at two addresses, y at one.
// Uses nothing from the package.
`default_nettype none

module cors_store #(
  parameter int unsigned NEURONS = 512
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(NEURONS)-1:0] waddr_i,
  input  logic signed [31:0]         wx_i,
  input  logic signed [31:0]         wy_i,
  input  logic [$clog2(NEURONS)-1:0] raddr_a_i,
  input  logic [$clog2(NEURONS)-1:0] raddr_b_i,
  output logic signed [31:0]         rx_a_o,
  output logic signed [31:0]         ry_a_o,
  output logic signed [31:0]         rx_b_o
);

  logic signed [31:0] x_mem [NEURONS];
  logic signed [31:0] y_mem [NEURONS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_mem[waddr_i] <= wx_i;
      y_mem[waddr_i] <= wy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_a_o <= x_mem[raddr_a_i];
    ry_a_o <= y_mem[raddr_a_i];
    rx_b_o <= x_mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== design/cors_tanh_tab.sv =====
// tanh magnitude table, Q1.16 values 0..1.0, filled after reset.
// Uses nothing from the package.
`default_nettype none

module cors_tanh_tab #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [16:0]              wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [16:0]              rdata_o
);

  logic [16:0] tab_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tab_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= tab_mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/coupled_oscillator_ring_step.sv =====
// Ring of relaxation oscillators with load, Euler step and read commands.
// Depends on cors_pkg, cors_mul, cors_div, cors_store, cors_tanh_tab, assert_macros.svh.
//
//  channel   dir  handshake                       contents
//  s_axis    in   s_axis_tvalid_i/tready_o        command word (mode, index, x, y)
//  m_axis    out  m_axis_tvalid_o/tready_i        x and y of the named neuron
//  cfg       in   cfg_valid_i/cfg_ready_o         register index and data, always ready
//
// A step runs every neuron through eight products on the one shared multiplier
// plus read, add and write-back. After reset the tanh table is built (the
// serial divider gives one bit a cycle); no command word is taken meanwhile.
// One command at a time: s_axis is ready only when idle and the result word
// has been taken, so a stalled m_axis holds off further commands.
`default_nettype none

module coupled_oscillator_ring_step #(
  parameter int unsigned NEURONS          = 512,
  parameter int unsigned TANH_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // neuron_index[8:0], load_x[40:9], load_y[72:41], pad
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // x_value[31:0], y_value[63:32]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cors_pkg::*;

  localparam int unsigned AW = $clog2(NEURONS);
  localparam int unsigned IW = $clog2(TANH_TABLE_DEPTH);

  // tanh table build constants, Q2.30: step h and tanh(h) from a 7th-order series
  localparam logic [63:0] TanhH  = (64'd1 << 32) / 64'(TANH_TABLE_DEPTH);
  localparam logic [63:0] TanhH2 = (TanhH * TanhH) >> 30;
  localparam logic [63:0] TanhH3 = (TanhH2 * TanhH) >> 30;
  localparam logic [63:0] TanhH5 = (TanhH3 * TanhH2) >> 30;
  localparam logic [63:0] TanhH7 = (TanhH5 * TanhH2) >> 30;
  localparam logic [63:0] TanhTh = TanhH + (64'd2 * TanhH5) / 64'd15 - TanhH3 / 64'd3
                                   - (64'd17 * TanhH7) / 64'd315;

  typedef enum logic [22:0] {
    ST_BUILD_WR  = 23'h000001,
    ST_BUILD_MUL = 23'h000002,
    ST_BUILD_DSET= 23'h000004,
    ST_BUILD_DIV = 23'h000008,
    ST_IDLE      = 23'h000010,
    ST_LOAD      = 23'h000020,
    ST_PRO1      = 23'h000040,
    ST_PRO2      = 23'h000080,
    ST_PRO3      = 23'h000100,
    ST_RD        = 23'h000200,
    ST_LD        = 23'h000400,
    ST_MXX       = 23'h000800,
    ST_MX3       = 23'h001000,
    ST_MU        = 23'h002000,
    ST_TRD       = 23'h004000,
    ST_MA        = 23'h008000,
    ST_G         = 23'h010000,
    ST_MF        = 23'h020000,
    ST_ME        = 23'h040000,
    ST_MD        = 23'h080000,
    ST_WR        = 23'h100000,
    ST_RDO       = 23'h200000,
    ST_RDW       = 23'h400000
  } st_e;

  st_e state_q, state_d;

  // configuration
  logic signed [31:0] theta_q, cw_q, cur_q, alpha_q, eps_q, invb_q;
  logic [30:0]        dt_q;

  // command
  logic [8:0]         idx_q;
  logic signed [31:0] lx_q, ly_q;
  logic [12:0]        idx_ext;
  logic               idx_ok;
  logic [AW-1:0]      idx_addr;

  // result word
  logic               m_tvalid_q;
  logic signed [31:0] out_x_q, out_y_q;

  // table build
  logic [30:0]        t_q;
  logic [IW-1:0]      k_q;
  logic [31:0]        t_rnd;
  logic [31:0]        t_sum;

  // step sequencing
  logic [AW-1:0]      i_q;
  logic [AW:0]        ip2;
  logic               ip2_wrap;
  logic [AW:0]        ip2_sub;
  logic [AW-1:0]      ip2_idx;
  logic               act0_q, act1_q, am2_q, am1_q, a0_q, ap1_q, ap2;
  logic               p2_wrap_q, p2_sel_q;
  logic signed [31:0] x_q, y_q, x3_q, s_q, f_q, g_q, dx_q;
  logic [2:0]         cnt_q;
  logic signed [35:0] acc_q;
  logic               u_neg_q, ovr_q;

  // shared units
  logic signed [31:0] mul_a, mul_b, qm, praw;
  logic signed [63:0] mul_p;
  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den, div_quot;
  div_status_t        div_st;

  // stores and table
  logic               st_we;
  logic [AW-1:0]      st_waddr, st_ra, st_rb;
  logic signed [31:0] st_wx, st_wy, rd_xa, rd_ya, rd_xb;
  logic               tab_we;
  logic [IW-1:0]      tab_raddr;
  logic [16:0]        tab_rdata;

  // tanh lookup address from u = x * inverse_beta
  logic [32:0]        u_abs;
  logic [30:0]        u_scaled;
  logic signed [31:0] tanh_mag, one_p_t;
  logic signed [31:0] x_new, y_new;
  logic               s_accept;

  cors_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  cors_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quot_o   (div_quot),
    .status_o (div_st)
  );

  cors_store #(.NEURONS(NEURONS)) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (st_waddr),
    .wx_i      (st_wx),
    .wy_i      (st_wy),
    .raddr_a_i (st_ra),
    .raddr_b_i (st_rb),
    .rx_a_o    (rd_xa),
    .ry_a_o    (rd_ya),
    .rx_b_o    (rd_xb)
  );

  cors_tanh_tab #(.DEPTH(TANH_TABLE_DEPTH)) u_tanh (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (k_q),
    .wdata_i (t_rnd[30:14]),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // handshakes
  assign s_axis_tready_o = (state_q == ST_IDLE) && !m_tvalid_q;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign cfg_ready_o     = 1'b1;

  assign idx_ext  = {4'd0, idx_q};
  assign idx_ok   = idx_ext < 13'(NEURONS);
  assign idx_addr = idx_ext[AW-1:0];

  // product views: Q16.16 (floor shift) and plain integer, both saturated
  assign qm   = sat32(mul_p >>> 16);
  assign praw = sat32(mul_p);

  // ring neighbor at distance +2
  assign ip2      = {1'b0, i_q} + (AW+1)'(2);
  assign ip2_wrap = ip2 >= (AW+1)'(NEURONS);
  assign ip2_sub  = ip2 - (AW+1)'(NEURONS);
  assign ip2_idx  = ip2_wrap ? ip2_sub[AW-1:0] : ip2[AW-1:0];
  // wrapped +2 neighbors are 0 and 1, already rewritten: use their saved activity
  assign ap2      = p2_wrap_q ? (p2_sel_q ? act1_q : act0_q) : (rd_xb >= theta_q);

  // |u| >= 4.0 saturates, else index = |u| * depth / 4.0
  assign u_abs     = qm[31] ? (33'd0 - 33'(qm)) : 33'(qm);
  assign u_scaled  = 31'(u_abs[17:0]) * 31'(TANH_TABLE_DEPTH);
  assign tab_raddr = u_scaled[18 +: IW];
  assign tanh_mag  = ovr_q ? QOne : 32'(tab_rdata);
  assign one_p_t   = u_neg_q ? (QOne - tanh_mag) : (QOne + tanh_mag);

  assign x_new = sat32(64'(x_q) + 64'(dx_q));
  assign y_new = sat32(64'(y_q) + 64'(qm));

  // table build arithmetic
  assign t_rnd     = {1'b0, t_q} + 32'd8192;
  assign t_sum     = {1'b0, t_q} + TanhTh[31:0];
  assign div_num   = {2'd0, t_sum, 30'd0};
  assign div_den   = 32'h4000_0000 + {2'd0, mul_p[59:30]};
  assign div_start = (state_q == ST_BUILD_DSET);
  assign tab_we    = (state_q == ST_BUILD_WR);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_BUILD_MUL: begin
        mul_a = {1'b0, t_q};
        mul_b = TanhTh[31:0];
      end
      ST_MXX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_MX3: begin
        mul_a = qm;
        mul_b = x_q;
      end
      ST_MU: begin
        mul_a = x_q;
        mul_b = invb_q;
      end
      ST_TRD: begin
        mul_a = {29'd0, cnt_q};
        mul_b = cw_q;
      end
      ST_MA: begin
        mul_a = alpha_q;
        mul_b = one_p_t;
      end
      ST_MF: begin
        mul_a = {1'b0, dt_q};
        mul_b = f_q;
      end
      ST_ME: begin
        mul_a = eps_q;
        mul_b = g_q;
      end
      ST_MD: begin
        mul_a = {1'b0, dt_q};
        mul_b = qm;
      end
      default: ;
    endcase
  end

  // store port select
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_addr;
    st_wx    = lx_q;
    st_wy    = ly_q;
    st_ra    = idx_addr;
    st_rb    = ip2_idx;
    case (state_q)
      ST_LOAD: st_we = idx_ok;
      ST_PRO1: begin
        st_ra = AW'(NEURONS - 2);
        st_rb = AW'(NEURONS - 1);
      end
      ST_PRO2: begin
        st_ra = '0;
        st_rb = AW'(1);
      end
      ST_RD: st_ra = i_q;
      ST_WR: begin
        st_we    = 1'b1;
        st_waddr = i_q;
        st_wx    = x_new;
        st_wy    = y_new;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_BUILD_WR:   state_d = (k_q == IW'(TANH_TABLE_DEPTH - 1)) ? ST_IDLE : ST_BUILD_MUL;
      ST_BUILD_MUL:  state_d = ST_BUILD_DSET;
      ST_BUILD_DSET: state_d = ST_BUILD_DIV;
      ST_BUILD_DIV:  if (div_st.done) state_d = ST_BUILD_WR;
      ST_IDLE: begin
        if (s_accept) begin
          case (mode_e'(s_axis_tuser_i))
            ModeLoad: state_d = ST_LOAD;
            ModeStep: state_d = ST_PRO1;
            default:  state_d = ST_RDO;
          endcase
        end
      end
      ST_LOAD: state_d = ST_RDO;
      ST_PRO1: state_d = ST_PRO2;
      ST_PRO2: state_d = ST_PRO3;
      ST_PRO3: state_d = ST_RD;
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_MXX;
      ST_MXX:  state_d = ST_MX3;
      ST_MX3:  state_d = ST_MU;
      ST_MU:   state_d = ST_TRD;
      ST_TRD:  state_d = ST_MA;
      ST_MA:   state_d = ST_G;
      ST_G:    state_d = ST_MF;
      ST_MF:   state_d = ST_ME;
      ST_ME:   state_d = ST_MD;
      ST_MD:   state_d = ST_WR;
      ST_WR:   state_d = (i_q == AW'(NEURONS - 1)) ? ST_RDO : ST_RD;
      ST_RDO:  state_d = ST_RDW;
      ST_RDW:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_BUILD_WR;
      m_tvalid_q <= 1'b0;
      t_q        <= '0;
      k_q        <= '0;
      i_q        <= '0;
    end else begin
      state_q <= state_d;
      if (m_tvalid_q && m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      if (state_q == ST_RDW) begin
        m_tvalid_q <= 1'b1;
      end
      if ((state_q == ST_BUILD_DIV) && div_st.done) begin
        t_q <= div_quot[30:0];
        k_q <= k_q + IW'(1);
      end
      if (state_q == ST_PRO1) begin
        i_q <= '0;
      end
      if (state_q == ST_WR) begin
        i_q <= i_q + AW'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= ThetaRst;
      cw_q    <= CouplingRst;
      cur_q   <= CurrentRst;
      alpha_q <= AlphaRst;
      eps_q   <= EpsilonRst;
      invb_q  <= InvBetaRst;
      dt_q    <= TimeStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTheta:    theta_q <= cfg_data_i;
        CfgCoupling: cw_q    <= cfg_data_i;
        CfgCurrent:  cur_q   <= cfg_data_i;
        CfgAlpha:    alpha_q <= cfg_data_i;
        CfgEpsilon:  eps_q   <= cfg_data_i;
        CfgInvBeta:  invb_q  <= cfg_data_i;
        CfgTimeStep: dt_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      idx_q <= s_axis_tdata_i[8:0];
      lx_q  <= s_axis_tdata_i[40:9];
      ly_q  <= s_axis_tdata_i[72:41];
    end
    case (state_q)
      ST_PRO2: begin
        am2_q <= rd_xa >= theta_q;
        am1_q <= rd_xb >= theta_q;
      end
      ST_PRO3: begin
        act0_q <= rd_xa >= theta_q;
        a0_q   <= rd_xa >= theta_q;
        act1_q <= rd_xb >= theta_q;
        ap1_q  <= rd_xb >= theta_q;
      end
      ST_RD: begin
        p2_wrap_q <= ip2_wrap;
        p2_sel_q  <= ip2_sub[0];
      end
      ST_LD: begin
        x_q   <= rd_xa;
        y_q   <= rd_ya;
        cnt_q <= 3'(am2_q) + 3'(am1_q) + 3'(ap1_q) + 3'(ap2);
        // next neuron's window, activity from old x only
        am2_q <= am1_q;
        am1_q <= a0_q;
        a0_q  <= ap1_q;
        ap1_q <= ap2;
      end
      ST_MU:  x3_q <= qm;
      ST_TRD: begin
        u_neg_q <= qm[31];
        ovr_q   <= u_abs[32:18] != '0;
      end
      ST_MA: begin
        s_q   <= praw;
        acc_q <= (36'(x_q) <<< 1) + 36'(x_q) - 36'(x3_q) + 36'(QTwo);
      end
      ST_G: begin
        g_q <= sat32(64'(qm) - 64'(y_q));
        f_q <= sat32(64'(acc_q) - 64'(y_q) + 64'(s_q) + 64'(cur_q));
      end
      ST_ME: dx_q <= qm;
      ST_RDW: begin
        out_x_q <= idx_ok ? rd_xa : 32'sd0;
        out_y_q <= idx_ok ? rd_ya : 32'sd0;
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_PROP(a_busy_after_accept, (s_accept |=> !s_axis_tready_o), "ready right after accept")
  `ASSERT_PROP(a_div_in_build, ((div_st.busy || div_st.done) |-> (state_q == ST_BUILD_DIV)), "divider active outside build")
  `ASSERT_PROP(a_result_from_read, ($rose(m_axis_tvalid_o) |-> $past(state_q == ST_RDW)), "result word without readback")
  `ASSERT_NEVER(a_ready_with_result, (s_axis_tready_o && m_axis_tvalid_o), "command taken while result waits")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the coupled oscillator ring: load, Euler step and read commands.
// Depends on cors_pkg and the coupled_oscillator_ring_step RTL.
`default_nettype none

// Tracks neuron state and registers, and queues the x/y word each command must return.
class ring_scoreboard;
  localparam int Ring = 512;
  localparam int LutDepth = 256;

  logic signed [31:0] x_mem [Ring];
  logic signed [31:0] y_mem [Ring];
  logic signed [31:0] tanh_lut [LutDepth];
  longint theta, weight, current, alpha, eps, inv_beta, dt;
  logic [63:0] pending_xy [$];
  int errors;

  function new();
    longint unsigned h, h2, h3, h5, h7, th, t;
    h  = (64'd1 << 32) / LutDepth;
    h2 = (h * h) >> 30;
    h3 = (h2 * h) >> 30;
    h5 = (h3 * h2) >> 30;
    h7 = (h5 * h2) >> 30;
    th = h + (2 * h5) / 15 - h3 / 3 - (17 * h7) / 315;
    t  = 0;
    for (int k = 0; k < LutDepth; k++) begin
      tanh_lut[k] = 32'((t + (64'd1 << 13)) >> 14);
      t = ((t + th) << 30) / ((64'd1 << 30) + ((t * th) >> 30));
    end
    theta = 32768; weight = 49152; current = 13107; alpha = 393216;
    eps = 1311; inv_beta = 655360; dt = 655;
    errors = 0;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, floor rounding, saturated
  function longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  function longint tanh_lookup(longint u);
    longint unsigned mag, idx;
    longint r;
    mag = (u < 0) ? longint'(-u) : longint'(u);
    idx = (mag * LutDepth) / (4 * 65536);
    r = (idx >= LutDepth) ? 65536 : longint'(tanh_lut[idx]);
    return (u < 0) ? -r : r;
  endfunction

  function void advance_ring();
    bit above [Ring];
    longint cnt, s, x, y, x3, f, g;
    for (int i = 0; i < Ring; i++) above[i] = longint'(x_mem[i]) >= theta;
    for (int i = 0; i < Ring; i++) begin
      cnt = longint'(above[(i + 1) % Ring]) + longint'(above[(i + 2) % Ring])
          + longint'(above[(i + Ring - 1) % Ring]) + longint'(above[(i + Ring - 2) % Ring]);
      s  = clamp32(cnt * weight);
      x  = x_mem[i];
      y  = y_mem[i];
      x3 = qmul(qmul(x, x), x);
      f  = clamp32(3 * x - x3 + 2 * 65536 - y + s + current);
      g  = clamp32(qmul(alpha, 65536 + tanh_lookup(qmul(x, inv_beta))) - y);
      x_mem[i] = 32'(clamp32(x + qmul(dt, f)));
      y_mem[i] = 32'(clamp32(y + qmul(dt, qmul(eps, g))));
    end
  endfunction

  function void set_reg(cors_pkg::cfg_idx_e idx, logic [31:0] d);
    case (idx)
      cors_pkg::CfgTheta:    theta    = longint'(signed'(d));
      cors_pkg::CfgCoupling: weight   = longint'(signed'(d));
      cors_pkg::CfgCurrent:  current  = longint'(signed'(d));
      cors_pkg::CfgAlpha:    alpha    = longint'(signed'(d));
      cors_pkg::CfgEpsilon:  eps      = longint'(signed'(d));
      cors_pkg::CfgInvBeta:  inv_beta = longint'(signed'(d));
      cors_pkg::CfgTimeStep: dt       = longint'({1'b0, d[30:0]});
      default: ;
    endcase
  endfunction

  function void note_command(logic [1:0] mode, logic [8:0] idx, logic [31:0] lx, logic [31:0] ly);
    if (mode == cors_pkg::ModeLoad) begin
      x_mem[idx] = lx;
      y_mem[idx] = ly;
    end else if (mode == cors_pkg::ModeStep) begin
      advance_ring();
    end
    pending_xy.push_back({y_mem[idx], x_mem[idx]});
  endfunction

  function void check_result(logic [63:0] word);
    logic [63:0] want;
    if (pending_xy.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, word);
      errors++;
      return;
    end
    want = pending_xy.pop_front();
    if (word[31:0] !== want[31:0]) begin
      $display("%0t: x_value expected %h actual %h", $time, want[31:0], word[31:0]);
      errors++;
    end
    if (word[63:32] !== want[63:32]) begin
      $display("%0t: y_value expected %h actual %h", $time, want[63:32], word[63:32]);
      errors++;
    end
  endfunction
endclass

module testbench;
  import cors_pkg::*;

  localparam int Ring = 512;
  localparam logic [1:0] ModeSpare = 2'd3;  // unused code, acts as a read
  localparam int StallLimit = 40000;        // longer than the tanh build or one step

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire         s_axis_tready_o, m_axis_tvalid_o, cfg_ready_o;
  wire  [63:0] m_axis_tdata_o;

  ring_scoreboard sb = new();
  bit loaded [Ring];
  int s_gap = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  coupled_oscillator_ring_step u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o,
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o, .m_axis_tready_i(m_tready), .m_axis_tdata_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog: any handshake resets the quiet counter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_tready && m_axis_tvalid_o) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result sink: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o);
    end
  end

  // one command word; valid stays up when the next word follows with no gap
  task automatic send_cmd(logic [1:0] mode, logic [8:0] idx, logic [31:0] lx, logic [31:0] ly);
    if (s_gap > 0) repeat (s_gap) @(posedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, ly, lx, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(mode, idx, lx, ly);
    if (mode == ModeLoad) loaded[idx] = 1'b1;
    s_gap = idle_on ? $urandom_range(0, 13) : 0;
    if (s_gap > 0) s_tvalid <= 1'b0;
  endtask

  // sender pauses until every pending word is back and the block settles
  task automatic drain();
    if (s_gap == 0) s_tvalid <= 1'b0;
    s_gap = 0;
    while (sb.pending_xy.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // register sets: defaults, all max, all min, random, moderate
  task automatic apply_setting(int k);
    logic [31:0] v [7];
    v = '{32'd32768, 32'd49152, 32'd13107, 32'd393216, 32'd1311, 32'd655360, 32'd655};
    case (k)
      1: foreach (v[i]) v[i] = 32'h7FFF_FFFF;
      2: begin
        foreach (v[i]) v[i] = 32'h8000_0000;
        v[CfgTimeStep] = 32'd0;
      end
      3: foreach (v[i]) v[i] = $urandom;
      4: begin
        v[CfgTheta] = $urandom_range(0, 4 * 65536) - 2 * 65536;
        v[CfgTimeStep] = 32'd3277;  // 0.05
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_e'(i), v[i]);
  endtask

  function automatic logic [31:0] draw_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 8 * 65536) - 4 * 65536;  // mostly within +-4.0
  endfunction

  task automatic run_random(int n);
    int r;
    logic [1:0] mode;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) mode = ModeLoad;
      else if (r < 70) mode = ModeRead;
      else if (r < 85) mode = ModeSpare;
      else mode = ModeStep;
      send_cmd(mode, 9'($urandom_range(0, Ring - 1)), draw_value(), draw_value());
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    apply_setting(0);

    // directed: field extremes, threshold tie, reads of loaded neurons only
    send_cmd(ModeLoad, 9'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(ModeLoad, 9'd511, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(ModeRead, 9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(ModeSpare, 9'd511, 32'd0, 32'd0);
    send_cmd(ModeLoad, 9'd3, 32'd32768, 32'd0);        // x exactly at theta
    send_cmd(ModeLoad, 9'd4, 32'd32767, 32'hFFFF_0000); // just below theta
    send_cmd(ModeLoad, 9'd256, 32'h0002_0000, 32'd0);
    send_cmd(ModeRead, 9'd256, 32'd0, 32'd0);
    // every neuron must hold a value before the first step
    for (int i = 0; i < Ring; i++)
      if (!loaded[i]) send_cmd(ModeLoad, 9'(i), draw_value(), draw_value());
    send_cmd(ModeStep, 9'd0, 32'd0, 32'd0);
    send_cmd(ModeStep, 9'd511, 32'd0, 32'd0);
    send_cmd(ModeRead, 9'd3, 32'd0, 32'd0);
    send_cmd(ModeSpare, 9'd4, 32'd0, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      apply_setting(ph == 5 ? 0 : ph);
      idle_on = (ph != 3);
      if (ph == 2) hold_req = 1'b1;
      run_random(25);
      if (ph == 1) drain();
      run_random(23);
    end

    drain();
    if (sb.errors == 0 && sb.pending_xy.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/cors_pkg.sv
design/cors_mul.sv
design/cors_div.sv
design/cors_store.sv
design/cors_tanh_tab.sv
design/coupled_oscillator_ring_step.sv
tb/sv/testbench.sv
